[hw/rtl/vtx_pkg.sv]
// Shared types, constants and helper functions of the vertex transform block.
package vtx_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int WORD_W     = 32;
   localparam int PROD_W     = 2 * WORD_W;
   localparam int SUM_W      = PROD_W + 2;
   // Dividend (n << FRAC_BITS); the quotient needs one more bit than it.
   localparam int DIVD_W     = WORD_W + FRAC_BITS;
   // Quotient bits resolved per divider stage.
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = (DIVD_W + 1 + DIV_STEP - 1) / DIV_STEP;
   // The shift register is as wide as the number of divider iterations.
   localparam int QUO_W      = DIV_STAGES * DIV_STEP;
   localparam int DIV_BITS   = QUO_W;

   localparam logic signed [WORD_W-1:0] ONE_FIX = WORD_W'(1) << FRAC_BITS;
   localparam logic signed [WORD_W-1:0] MAX_FIX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] MIN_FIX = {1'b1, {(WORD_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ACT_LOAD  = 3'd0,
      ACT_POINT = 3'd1,
      ACT_DIR   = 3'd2,
      ACT_VEC4  = 3'd3,
      ACT_VEC3  = 3'd4
   } action_type;

   typedef logic signed [WORD_W-1:0] fix_type;

   // Sideband that travels with a transform through the pipeline.
   typedef struct packed {
      logic need_div;
      logic sat;
   } flags_type;

   // Clamp a wide signed value to the 32-bit range.
   function automatic fix_type sat_fix(input logic signed [SUM_W-1:0] v,
                                       output logic hit);
      begin
         hit = 1'b0;
         if (v > SUM_W'(MAX_FIX)) begin
            hit = 1'b1;
            sat_fix = MAX_FIX;
         end else if (v < SUM_W'(MIN_FIX)) begin
            hit = 1'b1;
            sat_fix = MIN_FIX;
         end else begin
            sat_fix = v[WORD_W-1:0];
         end
      end
   endfunction

endpackage

[hw/rtl/vtx_mac.sv]
// Matrix store and the three-stage multiply, sum and round pipeline.
module vtx_mac (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [2:0]               in_action,
   input  logic [3:0]               in_index,
   input  vtx_pkg::fix_type         in_value,
   input  vtx_pkg::fix_type         in_x,
   input  vtx_pkg::fix_type         in_y,
   input  vtx_pkg::fix_type         in_z,
   input  vtx_pkg::fix_type         in_w,
   output logic                     out_valid,
   output vtx_pkg::fix_type         out_r [4],
   output vtx_pkg::flags_type       out_flags
);
   import vtx_pkg::*;

   fix_type matrix_ff [16];
   fix_type vec [4];
   logic    xform;

   // Stage 1: products.
   logic                        s1_valid_ff;
   logic                        s1_vec3_ff;
   logic                        s1_dirpt_ff;
   logic signed [PROD_W-1:0]    s1_prod_ff [16];
   // Stage 2: row sums.
   logic                        s2_valid_ff;
   logic                        s2_vec3_ff;
   logic                        s2_dirpt_ff;
   logic signed [SUM_W-1:0]     s2_sum_ff [4];
   // Stage 3: rounded and saturated rows.
   logic                        s3_valid_ff;
   fix_type                     s3_r_ff [4];
   flags_type                   s3_flags_ff;

   fix_type                     r_in [4];
   logic    [3:0]               hit;
   flags_type                   flags_in;

   assign xform = in_valid && (in_action == ACT_POINT || in_action == ACT_DIR
                  || in_action == ACT_VEC4 || in_action == ACT_VEC3);

   always_comb begin
      vec[0] = in_x;
      vec[1] = in_y;
      vec[2] = in_z;
      unique case (in_action)
         ACT_POINT: vec[3] = ONE_FIX;
         ACT_VEC4:  vec[3] = in_w;
         default:   vec[3] = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            matrix_ff[i] <= (i % 5 == 0) ? ONE_FIX : '0;
         end
      end else if (adv && in_valid && in_action == ACT_LOAD) begin
         matrix_ff[in_index] <= in_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= xform;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_vec3_ff  <= (in_action == ACT_VEC3);
         s1_dirpt_ff <= (in_action == ACT_POINT || in_action == ACT_DIR);
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               s1_prod_ff[c*4+r] <= PROD_W'(matrix_ff[c*4+r]) * PROD_W'(vec[c]);
            end
         end
         s2_vec3_ff  <= s1_vec3_ff;
         s2_dirpt_ff <= s1_dirpt_ff;
         for (int r = 0; r < 4; r++) begin
            s2_sum_ff[r] <= SUM_W'(s1_prod_ff[r]) + SUM_W'(s1_prod_ff[4+r])
                          + SUM_W'(s1_prod_ff[8+r]) + SUM_W'(s1_prod_ff[12+r]);
         end
         s3_r_ff     <= r_in;
         s3_flags_ff <= flags_in;
      end
   end

   // The exact sum shifted arithmetically equals floor of sum / 2^FRAC_BITS.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         r_in[r] = sat_fix(s2_sum_ff[r] >>> FRAC_BITS, hit[r]);
      end
      if (s2_vec3_ff) begin
         r_in[3] = '0;
      end
      flags_in.sat = (|hit[2:0]) || (hit[3] && !s2_vec3_ff);
      flags_in.need_div = s2_dirpt_ff && r_in[3] != '0 && r_in[3] != ONE_FIX;
   end

   assign out_valid = s3_valid_ff;
   assign out_r     = s3_r_ff;
   assign out_flags = s3_flags_ff;

endmodule

[hw/rtl/vtx_div.sv]
// Pipelined restoring divider for x, y and z by w, with saturation.
module vtx_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  vtx_pkg::fix_type         in_r [4],
   input  vtx_pkg::flags_type       in_flags,
   output logic                     out_valid,
   output vtx_pkg::fix_type         out_r [4],
   output logic                     out_divided,
   output logic                     out_sat
);
   import vtx_pkg::*;

   // Per stage: magnitudes of remainder/dividend and quotient for 3 lanes.
   logic                      v_ff   [DIV_STAGES+1];
   fix_type                   w_ff   [DIV_STAGES+1];
   flags_type                 f_ff   [DIV_STAGES+1];
   fix_type                   raw_ff [DIV_STAGES+1][3];
   logic                      neg_ff [DIV_STAGES+1][3];
   logic [QUO_W-1:0]          rem_ff [DIV_STAGES+1][3];
   logic [QUO_W-1:0]          quo_ff [DIV_STAGES+1][3];
   logic [WORD_W-1:0]         den_ff [DIV_STAGES+1];
   logic                      ov_v_ff;
   fix_type                   ov_r_ff [4];
   logic                      ov_div_ff;
   logic                      ov_sat_ff;

   logic [WORD_W-1:0]         den0;
   logic [QUO_W-1:0]          rem_n [DIV_STAGES][3];
   logic [QUO_W-1:0]          quo_n [DIV_STAGES][3];
   fix_type                   res_in [3];
   logic                      sat_in;

   assign den0 = in_r[3][WORD_W-1] ? WORD_W'(-in_r[3]) : in_r[3];

   // Stage 0 latches magnitudes; remaining stages do DIV_STEP bits each.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) v_ff[s] <= 1'b0;
         ov_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int s = 0; s < DIV_STAGES; s++) v_ff[s+1] <= v_ff[s];
         ov_v_ff <= v_ff[DIV_STAGES];
      end
   end

   always_comb begin
      logic [QUO_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic [QUO_W:0]   trial;
      for (int s = 0; s < DIV_STAGES; s++) begin
         for (int l = 0; l < 3; l++) begin
            rem = rem_ff[s][l];
            quo = quo_ff[s][l];
            for (int b = 0; b < DIV_STEP; b++) begin
               // Quotient register doubles as the dividend shift register.
               trial = {rem, quo[QUO_W-1]};
               quo   = {quo[QUO_W-2:0], 1'b0};
               if (trial >= (QUO_W+1)'(den_ff[s])) begin
                  trial  = trial - (QUO_W+1)'(den_ff[s]);
                  quo[0] = 1'b1;
               end
               rem = trial[QUO_W-1:0];
            end
            rem_n[s][l] = rem;
            quo_n[s][l] = quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff[0]   <= in_r[3];
         f_ff[0]   <= in_flags;
         den_ff[0] <= (den0 == '0) ? WORD_W'(1) : den0;
         for (int l = 0; l < 3; l++) begin
            raw_ff[0][l] <= in_r[l];
            neg_ff[0][l] <= in_r[l][WORD_W-1] ^ in_r[3][WORD_W-1];
            rem_ff[0][l] <= '0;
            quo_ff[0][l] <= QUO_W'({(in_r[l][WORD_W-1] ? WORD_W'(-in_r[l]) : in_r[l]),
                                    {FRAC_BITS{1'b0}}})
                            << (QUO_W - DIV_BITS);
         end
         for (int s = 0; s < DIV_STAGES; s++) begin
            w_ff[s+1]   <= w_ff[s];
            f_ff[s+1]   <= f_ff[s];
            den_ff[s+1] <= den_ff[s];
            for (int l = 0; l < 3; l++) begin
               raw_ff[s+1][l] <= raw_ff[s][l];
               neg_ff[s+1][l] <= neg_ff[s][l];
               rem_ff[s+1][l] <= rem_n[s][l];
               quo_ff[s+1][l] <= quo_n[s][l];
            end
         end
         ov_r_ff[0] <= res_in[0];
         ov_r_ff[1] <= res_in[1];
         ov_r_ff[2] <= res_in[2];
         ov_r_ff[3] <= w_ff[DIV_STAGES];
         ov_div_ff  <= f_ff[DIV_STAGES].need_div;
         ov_sat_ff  <= f_ff[DIV_STAGES].sat || sat_in;
      end
   end

   // Sign fix-up and clamp of the quotient magnitude.
   always_comb begin
      logic [QUO_W-1:0] mag;
      sat_in = 1'b0;
      for (int l = 0; l < 3; l++) begin
         mag = quo_ff[DIV_STAGES][l];
         if (!f_ff[DIV_STAGES].need_div) begin
            res_in[l] = raw_ff[DIV_STAGES][l];
         end else if (neg_ff[DIV_STAGES][l]) begin
            if (mag > QUO_W'({1'b1, {(WORD_W-1){1'b0}}})) begin
               res_in[l] = MIN_FIX;
               sat_in    = 1'b1;
            end else begin
               res_in[l] = WORD_W'(-mag);
            end
         end else if (mag > QUO_W'(MAX_FIX)) begin
            res_in[l] = MAX_FIX;
            sat_in    = 1'b1;
         end else begin
            res_in[l] = mag[WORD_W-1:0];
         end
      end
   end

   assign out_valid   = ov_v_ff;
   assign out_r       = ov_r_ff;
   assign out_divided = ov_div_ff;
   assign out_sat     = ov_sat_ff;

endmodule

[hw/rtl/vertex_transform_4x4_core.sv]
// Top level of the 4x4 homogeneous vertex transform with perspective divide.
//
// Input transactions arrive on the req_ stream. A load transaction (action 0)
// writes one Q16.16 matrix entry, column-major, and produces no result. Point,
// direction, four-vector and three-vector transactions each produce exactly
// one result transaction on the rsp_ stream; unused action codes are dropped.
// The block is a single in-order pipeline: three stages form the products,
// row sums and rounded rows, then a radix-16 restoring divider spread over
// one stage per four quotient bits divides x, y and z by w when a point or
// direction yields a w other than 0 and 1.0. Every transform passes through
// the same stages, divided or not. Throughput is one transaction per cycle
// while the output is not stalled. A load takes effect for the next
// transaction accepted after it.
// Reset restores the identity matrix and empties the pipeline. When the
// receiver deasserts rsp_tready while a result is waiting, the whole pipeline
// freezes in place and req_tready falls, so nothing is lost or repeated.
module vertex_transform_4x4_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: action[2:0], entry_index[6:3], entry_value[38:7], x_in[70:39],
   // y_in[102:71], z_in[134:103], w_in[166:135], zero pad [167].
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96].
   output logic [127:0] rsp_tdata,
   // tuser: divided[0], saturated[1].
   output logic [1:0]   rsp_tuser
);
   import vtx_pkg::*;

   logic      adv;
   logic      mac_valid;
   fix_type   mac_r [4];
   flags_type mac_flags;
   fix_type   div_r [4];
   logic      div_divided;
   logic      div_sat;

   // Stall everything whenever a finished result sits untaken.
   assign adv        = rsp_tready || !rsp_tvalid;
   assign req_tready = adv;

   vtx_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_action (req_tdata[2:0]),
      .in_index  (req_tdata[6:3]),
      .in_value  (req_tdata[38:7]),
      .in_x      (req_tdata[70:39]),
      .in_y      (req_tdata[102:71]),
      .in_z      (req_tdata[134:103]),
      .in_w      (req_tdata[166:135]),
      .out_valid (mac_valid),
      .out_r     (mac_r),
      .out_flags (mac_flags)
   );

   vtx_div u_div (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (mac_valid),
      .in_r        (mac_r),
      .in_flags    (mac_flags),
      .out_valid   (rsp_tvalid),
      .out_r       (div_r),
      .out_divided (div_divided),
      .out_sat     (div_sat)
   );

   assign rsp_tdata = {div_r[3], div_r[2], div_r[1], div_r[0]};
   assign rsp_tuser = {div_sat, div_divided};

   // A divided result never has w equal to zero or one.
   a_div_w : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[127:96] != '0
                                  && rsp_tdata[127:96] != ONE_FIX)
      else $error("divided result with trivial w");

   // A stalled result stays put.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");

   // No intake while the output is blocked.
   a_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted during stall");

endmodule
